// ===== rtl/pnmh_pkg.sv =====
package pnmh_pkg;

	localparam int unsigned ValW = 31;
	localparam int unsigned LenW = 32;

	localparam logic [ValW-1:0] VAL_MAX = {ValW{1'b1}};

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] MAGIC_NONE = 3'd0;
	localparam logic [2:0] MAGIC_P1   = 3'd1;
	localparam logic [2:0] MAGIC_P3   = 3'd3;
	localparam logic [2:0] MAGIC_P4   = 3'd4;
	localparam logic [2:0] MAGIC_P6   = 3'd6;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_MAGIC = 2'd1,
		ST_MAXV_ZERO = 2'd2,
		ST_TOO_LARGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_BOOL   = 2'd0,
		KIND_BYTE   = 2'd1,
		KIND_UINT16 = 2'd2,
		KIND_UINT32 = 2'd3
	} kind_t;

	localparam logic [5:0] BITS_NONE = 6'd0;
	localparam logic [5:0] BITS_1    = 6'd1;
	localparam logic [5:0] BITS_8    = 6'd8;
	localparam logic [5:0] BITS_16   = 6'd16;
	localparam logic [5:0] BITS_24   = 6'd24;
	localparam logic [5:0] BITS_32   = 6'd32;

	localparam logic [1:0] COMPS_NONE = 2'd0;
	localparam logic [1:0] COMPS_GRAY = 2'd1;
	localparam logic [1:0] COMPS_RGB  = 2'd3;

	typedef enum logic [9:0] {
		PH_IDLE   = 10'b00_0000_0001,
		PH_M0     = 10'b00_0000_0010,
		PH_M1     = 10'b00_0000_0100,
		PH_M2     = 10'b00_0000_1000,
		PH_SKIP_W = 10'b00_0001_0000,
		PH_NUM_W  = 10'b00_0010_0000,
		PH_SKIP_H = 10'b00_0100_0000,
		PH_NUM_H  = 10'b00_1000_0000,
		PH_SKIP_M = 10'b01_0000_0000,
		PH_NUM_M  = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		status_t         status;
		logic [2:0]      magic_number;
		logic [ValW-1:0] image_width;
		logic [ValW-1:0] image_height;
		logic [ValW-1:0] max_value;
		logic [1:0]      components;
		logic [5:0]      bits_per_sample;
		kind_t           pixel_kind;
		logic [LenW-1:0] header_length;
	} result_t;

endpackage

// ===== rtl/pnmh_parse.sv =====
module pnmh_parse
	import pnmh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       start_of_file,
	output logic       emit,
	output result_t    res
);

	phase_t          phase_q, ph, ph_n;
	logic            comment_q, cm, cm_n;
	logic [ValW-1:0] acc_q, acc, acc_n;
	logic [ValW-1:0] wd_q, wd, wd_n;
	logic [ValW-1:0] ht_q, ht, ht_n;
	logic [2:0]      mg_q, mg, mg_n;
	logic            ovf_q, ovf, ovf_n;
	logic            bad_q, bad, bad_n;
	logic [LenW-1:0] cnt_q, cnt, cnt_n;

	logic            is_dig, is_ws, is_eol, is_hash, is_other, bitmap;
	logic [34:0]     prod;
	logic [ValW-1:0] acc_dig, endv, mv;
	logic            ovf_dig, fin_w, fin_h, fin_m, casc_h, casc_m, in_num;
	logic            ws_end, bad_res;
	status_t         st;

	assign is_dig   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign is_eol   = (data_byte == CH_LF) || (data_byte == CH_CR);
	assign is_ws    = is_eol || (data_byte == CH_SPACE) || (data_byte == CH_TAB);
	assign is_hash  = (data_byte == CH_HASH);
	assign is_other = !is_dig && !is_ws && !is_hash;

	always_comb begin
		ph  = start_of_file ? PH_M0 : phase_q;
		cm  = start_of_file ? 1'b0 : comment_q;
		acc = start_of_file ? '0 : acc_q;
		wd  = start_of_file ? '0 : wd_q;
		ht  = start_of_file ? '0 : ht_q;
		mg  = start_of_file ? MAGIC_NONE : mg_q;
		ovf = start_of_file ? 1'b0 : ovf_q;
		bad = start_of_file ? 1'b0 : bad_q;
		cnt = start_of_file ? '0 : cnt_q;
	end

	// multiply by ten and add the digit
	assign prod = {1'b0, endv, 3'b000} + {3'b000, endv, 1'b0}
		+ {31'd0, data_byte[3:0]};
	assign ovf_dig = (prod[34:31] != 4'd0);
	assign acc_dig = ovf_dig ? VAL_MAX : prod[ValW-1:0];

	assign bitmap = (mg == MAGIC_P1) || (mg == MAGIC_P4);
	assign in_num = (ph == PH_NUM_W) || (ph == PH_NUM_H) || (ph == PH_NUM_M);
	assign endv   = in_num ? acc : '0;
	assign fin_w  = ((ph == PH_NUM_W) && !is_dig) || ((ph == PH_SKIP_W) && !cm && is_other);
	assign fin_h  = ((ph == PH_NUM_H) && !is_dig) || ((ph == PH_SKIP_H) && !cm && is_other);
	assign fin_m  = ((ph == PH_NUM_M) && !is_dig) || ((ph == PH_SKIP_M) && !cm && is_other);

	always_comb begin
		ph_n    = ph;
		cm_n    = cm;
		acc_n   = acc;
		wd_n    = wd;
		ht_n    = ht;
		mg_n    = mg;
		ovf_n   = ovf;
		bad_n   = bad;
		cnt_n   = cnt;
		emit    = 1'b0;
		st      = ST_OK;
		mv      = '0;
		ws_end  = 1'b0;
		bad_res = 1'b0;
		casc_h  = 1'b0;
		casc_m  = 1'b0;
		if (ph != PH_IDLE) begin
			cnt_n = (cnt == {LenW{1'b1}}) ? cnt : cnt + 32'd1;
		end
		unique case (ph)
			PH_IDLE: begin
			end
			PH_M0: begin
				bad_n = (data_byte != CH_P);
				ph_n  = PH_M1;
			end
			PH_M1: begin
				if ((data_byte >= CH_ONE) && (data_byte <= CH_SIX)) begin
					mg_n = data_byte[2:0];
				end else begin
					bad_n = 1'b1;
				end
				ph_n = PH_M2;
			end
			PH_M2: begin
				if (bad || !is_ws) begin
					bad_n   = 1'b1;
					mg_n    = MAGIC_NONE;
					wd_n    = '0;
					ht_n    = '0;
					emit    = 1'b1;
					bad_res = 1'b1;
					st      = ST_BAD_MAGIC;
					ph_n    = PH_IDLE;
				end else begin
					ph_n = PH_SKIP_W;
				end
			end
			PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
				if (cm) begin
					if (is_eol) begin
						cm_n = 1'b0;
					end
				end else if (is_hash) begin
					cm_n = 1'b1;
				end else if (is_dig) begin
					acc_n = acc_dig;
					ovf_n = ovf || ovf_dig;
					ph_n  = (ph == PH_SKIP_W) ? PH_NUM_W :
						(ph == PH_SKIP_H) ? PH_NUM_H : PH_NUM_M;
				end
			end
			PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
				if (is_dig) begin
					acc_n = acc_dig;
					ovf_n = ovf || ovf_dig;
				end
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase

		// a number ends; an unexpected byte closes every later number as zero
		if (fin_w) begin
			wd_n = endv;
			if (is_other) begin
				casc_h = 1'b1;
			end else begin
				ph_n = PH_SKIP_H;
				cm_n = is_hash;
			end
		end
		if (fin_h || casc_h) begin
			ht_n = fin_h ? endv : '0;
			if (bitmap) begin
				emit   = 1'b1;
				st     = ovf ? ST_TOO_LARGE : ST_OK;
				mv     = {{(ValW-1){1'b0}}, 1'b1};
				ws_end = is_ws;
				ph_n   = PH_IDLE;
			end else if (is_other) begin
				casc_m = 1'b1;
			end else begin
				ph_n = PH_SKIP_M;
				cm_n = is_hash;
			end
		end
		if (fin_m || casc_m) begin
			mv     = fin_m ? endv : '0;
			emit   = 1'b1;
			st     = (mv == '0) ? ST_MAXV_ZERO : (ovf ? ST_TOO_LARGE : ST_OK);
			ws_end = is_ws;
			ph_n   = PH_IDLE;
		end
	end

	always_comb begin
		res.status          = st;
		res.magic_number    = mg_n;
		res.image_width     = wd_n;
		res.image_height    = ht_n;
		res.max_value       = mv;
		res.components      = COMPS_NONE;
		res.bits_per_sample = BITS_NONE;
		res.pixel_kind      = KIND_BOOL;
		if (bad_res) begin
			res.header_length = '0;
		end else if (ws_end && (cnt != {LenW{1'b1}})) begin
			res.header_length = cnt + 32'd1;
		end else begin
			res.header_length = cnt;
		end
		if (st == ST_OK) begin
			res.components = ((mg == MAGIC_P3) || (mg == MAGIC_P6)) ? COMPS_RGB : COMPS_GRAY;
			priority if (bitmap) begin
				res.bits_per_sample = BITS_1;
				res.pixel_kind      = KIND_BOOL;
			end else if (mv[ValW-1:8] == '0) begin
				res.bits_per_sample = BITS_8;
				res.pixel_kind      = KIND_BYTE;
			end else if (mv[ValW-1:16] == '0) begin
				res.bits_per_sample = BITS_16;
				res.pixel_kind      = KIND_UINT16;
			end else if (mv[ValW-1:24] == '0) begin
				res.bits_per_sample = BITS_24;
				res.pixel_kind      = KIND_UINT32;
			end else begin
				res.bits_per_sample = BITS_32;
				res.pixel_kind      = KIND_UINT32;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			comment_q <= 1'b0;
			acc_q     <= '0;
			wd_q      <= '0;
			ht_q      <= '0;
			mg_q      <= MAGIC_NONE;
			ovf_q     <= 1'b0;
			bad_q     <= 1'b0;
			cnt_q     <= '0;
		end else if (step) begin
			phase_q   <= ph_n;
			comment_q <= cm_n;
			acc_q     <= acc_n;
			wd_q      <= wd_n;
			ht_q      <= ht_n;
			mg_q      <= mg_n;
			ovf_q     <= ovf_n;
			bad_q     <= bad_n;
			cnt_q     <= cnt_n;
		end
	end

endmodule

// ===== rtl/pnm_header_parser_top.sv =====
// channel   direction  handshake                   payload
// byte      in         byte_valid / byte_ready     data_byte, start_of_file
// result    out        result_valid / result_ready status .. header_length
//
// one byte per cycle sustained while no stalled result holds back a byte; a result
// passes the input register, then the result register, after its byte is accepted
// the parse state loop runs combinationally from the byte register to the state registers
// arst_n clears the parser to waiting for a start byte and empties both registers
// a stalled result blocks only bytes that would produce another result

module pnm_header_parser_top
	import pnmh_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_ready,
	input  logic [7:0]      data_byte,
	input  logic            start_of_file,
	output logic            result_valid,
	input  logic            result_ready,
	output logic [1:0]      status,
	output logic [2:0]      magic_number,
	output logic [ValW-1:0] image_width,
	output logic [ValW-1:0] image_height,
	output logic [ValW-1:0] max_value,
	output logic [1:0]      components,
	output logic [5:0]      bits_per_sample,
	output logic [1:0]      pixel_kind,
	output logic [LenW-1:0] header_length
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       sof_s1;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res;
	logic       emit;
	logic       adv;

	assign adv        = valid_s1 && (!emit || !out_valid_q || result_ready);
	assign byte_ready = !valid_s1 || adv;

	pnmh_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv),
		.data_byte     (byte_s1),
		.start_of_file (sof_s1),
		.emit          (emit),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1 <= data_byte;
			sof_s1  <= start_of_file;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= res;
		end
	end

	assign result_valid    = out_valid_q;
	assign status          = res_q.status;
	assign magic_number    = res_q.magic_number;
	assign image_width     = res_q.image_width;
	assign image_height    = res_q.image_height;
	assign max_value       = res_q.max_value;
	assign components      = res_q.components;
	assign bits_per_sample = res_q.bits_per_sample;
	assign pixel_kind      = res_q.pixel_kind;
	assign header_length   = res_q.header_length;

endmodule

// ===== rtl/pnmh_checker.sv =====
module pnmh_checker
	import pnmh_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            byte_valid,
	input logic            byte_ready,
	input logic [7:0]      data_byte,
	input logic            start_of_file,
	input logic            result_valid,
	input logic            result_ready,
	input logic [1:0]      status,
	input logic [2:0]      magic_number,
	input logic [ValW-1:0] image_width,
	input logic [ValW-1:0] image_height,
	input logic [ValW-1:0] max_value,
	input logic [1:0]      components,
	input logic [5:0]      bits_per_sample,
	input logic [1:0]      pixel_kind,
	input logic [LenW-1:0] header_length
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(status)
			&& $stable(header_length) && $stable(image_width))
		else $error("result transaction changed while stalled");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_OK) |-> (components == COMPS_NONE)
			&& (bits_per_sample == BITS_NONE) && (pixel_kind == KIND_BOOL))
		else $error("error transaction carries pixel format");

	a_bad_magic: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_BAD_MAGIC) |-> (magic_number == MAGIC_NONE)
			&& (image_width == '0) && (image_height == '0) && (header_length == '0))
		else $error("bad magic transaction with nonzero fields");

	a_bitmap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_OK)
			&& ((magic_number == MAGIC_P1) || (magic_number == MAGIC_P4))
			|-> (max_value == 1) && (bits_per_sample == BITS_1))
		else $error("bitmap transaction with wrong sample format");

	a_ok_format: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_OK) |-> (components != COMPS_NONE)
			&& (bits_per_sample != BITS_NONE) && (max_value != '0))
		else $error("ok transaction without a sample format");

endmodule

bind pnm_header_parser_top pnmh_checker u_pnmh_checker (.*);

// ===== bench/tb_pnm_header_parser_top.sv =====
module tb_pnm_header_parser_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pnmh_pkg::*;

	localparam int unsigned RANDOM_BYTES = 460;
	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned DRAIN_CYCLES = 8;

	logic            clk;
	logic            arst_n;
	logic            byte_valid;
	logic            byte_ready;
	logic [7:0]      data_byte;
	logic            start_of_file;
	logic            result_valid;
	logic            result_ready;
	logic [1:0]      status;
	logic [2:0]      magic_number;
	logic [ValW-1:0] image_width;
	logic [ValW-1:0] image_height;
	logic [ValW-1:0] max_value;
	logic [1:0]      components;
	logic [5:0]      bits_per_sample;
	logic [1:0]      pixel_kind;
	logic [LenW-1:0] header_length;

	pnm_header_parser_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_ready      (byte_ready),
		.data_byte       (data_byte),
		.start_of_file   (start_of_file),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.status          (status),
		.magic_number    (magic_number),
		.image_width     (image_width),
		.image_height    (image_height),
		.max_value       (max_value),
		.components      (components),
		.bits_per_sample (bits_per_sample),
		.pixel_kind      (pixel_kind),
		.header_length   (header_length)
	);

	localparam result_t UNTYPED = '{ST_OK, MAGIC_NONE, 31'd0, 31'd0, 31'd0,
		COMPS_NONE, BITS_NONE, KIND_BOOL, 32'd0};
	localparam result_t BAD_MAGIC_HDR = '{ST_BAD_MAGIC, MAGIC_NONE, 31'd0, 31'd0, 31'd0,
		COMPS_NONE, BITS_NONE, KIND_BOOL, 32'd0};

	typedef struct {
		string   text;
		bit      sof;
		bit      typed;
		result_t want;
	} dir_row_t;

	dir_row_t dir_rows [19] = '{
		'{"P1 2 3 ", 1'b1, 1'b1, '{ST_OK, MAGIC_P1, 31'd2, 31'd3, 31'd1,
			COMPS_GRAY, BITS_1, KIND_BOOL, 32'd7}},
		'{"X5 ", 1'b1, 1'b1, BAD_MAGIC_HDR},
		'{"P7\n", 1'b1, 1'b1, BAD_MAGIC_HDR},
		'{"P3x", 1'b1, 1'b1, BAD_MAGIC_HDR},
		'{"P0\t", 1'b1, 1'b1, BAD_MAGIC_HDR},
		'{"P2 12", 1'b1, 1'b0, UNTYPED},
		'{"P5\t3 4 255\015", 1'b1, 1'b0, UNTYPED},
		'{"zz9", 1'b0, 1'b0, UNTYPED},
		'{"P6 #c\n1#x\0152 65535 ", 1'b1, 1'b0, UNTYPED},
		'{"P6 0 0 0 ", 1'b1, 1'b1, '{ST_MAXV_ZERO, MAGIC_P6, 31'd0, 31'd0, 31'd0,
			COMPS_NONE, BITS_NONE, KIND_BOOL, 32'd9}},
		'{"P4 99999999999 1x", 1'b1, 1'b0, UNTYPED},
		'{"P2 9999999999 1 0 ", 1'b1, 1'b0, UNTYPED},
		'{"P2 1 1 16777216 ", 1'b1, 1'b0, UNTYPED},
		'{"P3 1 1 16777215 ", 1'b1, 1'b0, UNTYPED},
		'{"P2 1 1 256\t", 1'b1, 1'b0, UNTYPED},
		'{"P5 1 1 \377", 1'b1, 1'b0, UNTYPED},
		'{"P6 2147483647 2147483647 2147483647 ", 1'b1, 1'b0, UNTYPED},
		'{"P3 2147483648 1 255 ", 1'b1, 1'b0, UNTYPED},
		'{"P4\0151 1\n", 1'b1, 1'b0, UNTYPED}
	};

	// parser state mirror
	phase_t          ph;
	bit              in_cmt;
	logic [31:0]     acc;
	logic [ValW-1:0] sw;
	logic [ValW-1:0] sh;
	logic [2:0]      smag;
	bit              ovf;
	logic [31:0]     nbytes;
	bit              badmag;

	result_t    pending_headers [$];
	logic [7:0] file_q [$];
	result_t    head_res;
	int         mismatches;
	int         idle_cycles;
	bit         calm;

	function automatic bit is_eol(logic [7:0] b);
		return b == CH_LF || b == CH_CR;
	endfunction

	function automatic bit is_ws(logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
	endfunction

	function automatic void reset_parser();
		ph = PH_IDLE;
		in_cmt = 1'b0;
		acc = '0;
		sw = '0;
		sh = '0;
		smag = MAGIC_NONE;
		ovf = 1'b0;
		nbytes = '0;
		badmag = 1'b0;
	endfunction

	function automatic result_t make_header(status_t st, logic [31:0] mv,
		logic [31:0] prev_cnt, bit ws_end);
		result_t r;
		logic [32:0] len;
		len = {1'b0, prev_cnt} + 33'(ws_end);
		r.status = st;
		r.magic_number = smag;
		r.image_width = sw;
		r.image_height = sh;
		r.max_value = mv[ValW-1:0];
		r.components = COMPS_NONE;
		r.bits_per_sample = BITS_NONE;
		r.pixel_kind = KIND_BOOL;
		r.header_length = len[32] ? '1 : len[31:0];
		if (st == ST_OK) begin
			r.components = (smag == MAGIC_P3 || smag == MAGIC_P6) ? COMPS_RGB : COMPS_GRAY;
			if (smag == MAGIC_P1 || smag == MAGIC_P4) begin
				r.bits_per_sample = BITS_1;
				r.pixel_kind = KIND_BOOL;
			end else if (mv <= 32'hFF) begin
				r.bits_per_sample = BITS_8;
				r.pixel_kind = KIND_BYTE;
			end else if (mv <= 32'hFFFF) begin
				r.bits_per_sample = BITS_16;
				r.pixel_kind = KIND_UINT16;
			end else if (mv <= 32'hFF_FFFF) begin
				r.bits_per_sample = BITS_24;
				r.pixel_kind = KIND_UINT32;
			end else begin
				r.bits_per_sample = BITS_32;
				r.pixel_kind = KIND_UINT32;
			end
		end
		ph = PH_IDLE;
		return r;
	endfunction

	// advances the mirror by one byte; returns 1 when a header result is due
	function automatic bit parse_byte(logic [7:0] b, bit sof, output result_t r);
		logic [31:0] prev_cnt;
		logic [63:0] v;
		status_t     st;
		r = UNTYPED;
		if (sof) begin
			reset_parser();
			ph = PH_M0;
		end
		if (ph == PH_IDLE)
			return 1'b0;
		prev_cnt = nbytes;
		if (nbytes != '1)
			nbytes++;
		case (ph)
			PH_M0: begin
				badmag = (b != CH_P);
				ph = PH_M1;
				return 1'b0;
			end
			PH_M1: begin
				if (b >= CH_ONE && b <= CH_SIX)
					smag = 3'(b - CH_ZERO);
				else
					badmag = 1'b1;
				ph = PH_M2;
				return 1'b0;
			end
			PH_M2: begin
				if (!is_ws(b))
					badmag = 1'b1;
				if (badmag) begin
					smag = MAGIC_NONE;
					sw = '0;
					sh = '0;
					r = make_header(ST_BAD_MAGIC, 32'd0, 32'd0, 1'b0);
					return 1'b1;
				end
				ph = PH_SKIP_W;
				return 1'b0;
			end
			default: ;
		endcase
		for (int guard = 0; guard < 8; guard++) begin
			if (ph == PH_SKIP_W || ph == PH_SKIP_H || ph == PH_SKIP_M) begin
				if (in_cmt) begin
					if (is_eol(b))
						in_cmt = 1'b0;
					return 1'b0;
				end
				if (b == CH_HASH) begin
					in_cmt = 1'b1;
					return 1'b0;
				end
				if (is_ws(b))
					return 1'b0;
				acc = '0;
				case (ph)
					PH_SKIP_W: ph = PH_NUM_W;
					PH_SKIP_H: ph = PH_NUM_H;
					default:   ph = PH_NUM_M;
				endcase
				continue;
			end
			if (b >= CH_ZERO && b <= CH_NINE) begin
				v = 64'(acc) * 64'd10 + 64'(b - CH_ZERO);
				if (v > 64'(VAL_MAX)) begin
					v = 64'(VAL_MAX);
					ovf = 1'b1;
				end
				acc = v[31:0];
				return 1'b0;
			end
			if (ph == PH_NUM_W) begin
				sw = acc[ValW-1:0];
				ph = PH_SKIP_H;
				continue;
			end
			if (ph == PH_NUM_H) begin
				sh = acc[ValW-1:0];
				if (smag == MAGIC_P1 || smag == MAGIC_P4) begin
					if (ovf)
						st = ST_TOO_LARGE;
					else
						st = ST_OK;
					r = make_header(st, 32'd1, prev_cnt, is_ws(b));
					return 1'b1;
				end
				ph = PH_SKIP_M;
				continue;
			end
			if (acc == '0)
				st = ST_MAXV_ZERO;
			else if (ovf)
				st = ST_TOO_LARGE;
			else
				st = ST_OK;
			r = make_header(st, acc, prev_cnt, is_ws(b));
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] pick_ws();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_non_digit();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b >= CH_ZERO && b <= CH_NINE);
		return b;
	endfunction

	// mostly well-formed headers with random separators, comments and numbers
	task automatic build_file();
		int form;
		int nums;
		int digits;
		int cut;
		file_q.delete();
		form = $urandom_range(0, 99);
		file_q.push_back(CH_P);
		file_q.push_back(8'(CH_ONE + $urandom_range(0, 5)));
		file_q.push_back(pick_ws());
		nums = (3'(file_q[1] - CH_ZERO) == MAGIC_P1 || 3'(file_q[1] - CH_ZERO) == MAGIC_P4)
			? 2 : 3;
		for (int n = 0; n < nums; n++) begin
			repeat ($urandom_range(0, 2)) begin
				if ($urandom_range(0, 2) == 0) begin
					file_q.push_back(CH_HASH);
					repeat ($urandom_range(0, 6))
						file_q.push_back(8'($urandom_range(32, 126)));
					file_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
				end else begin
					file_q.push_back(pick_ws());
				end
			end
			case ($urandom_range(0, 19))
				0: digits = 0;
				1, 2: digits = $urandom_range(9, 12);
				default: digits = $urandom_range(1, 4);
			endcase
			repeat (digits)
				file_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
			if ($urandom_range(0, 7) == 0)
				file_q.push_back(pick_non_digit());
			else
				file_q.push_back(pick_ws());
		end
		if (form < 6) begin
			file_q[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
		end else if (form < 12) begin
			cut = $urandom_range(1, file_q.size() - 1);
			while (file_q.size() > cut)
				void'(file_q.pop_back());
		end
	endtask

	task automatic send_byte(logic [7:0] b, bit sof, bit typed, result_t want);
		int      gap;
		bit      got;
		result_t r;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		start_of_file <= sof;
		do @(posedge clk); while (!byte_ready);
		got = parse_byte(b, sof, r);
		if (got)
			pending_headers.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic cmp(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s: expected %0h, actual %0h", $realtime, name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_headers.size() == 0) begin
				$display("%0t unexpected result: expected none, actual status %0h",
					$realtime, status);
				mismatches++;
			end else begin
				head_res = pending_headers.pop_front();
				cmp("status", 32'(head_res.status), 32'(status));
				cmp("magic_number", 32'(head_res.magic_number), 32'(magic_number));
				cmp("image_width", 32'(head_res.image_width), 32'(image_width));
				cmp("image_height", 32'(head_res.image_height), 32'(image_height));
				cmp("max_value", 32'(head_res.max_value), 32'(max_value));
				cmp("components", 32'(head_res.components), 32'(components));
				cmp("bits_per_sample", 32'(head_res.bits_per_sample), 32'(bits_per_sample));
				cmp("pixel_kind", 32'(head_res.pixel_kind), 32'(pixel_kind));
				cmp("header_length", head_res.header_length, header_length);
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_valid && byte_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t watchdog: no transaction for %0d cycles", $realtime, idle_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int stall;
		result_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	initial begin
		int sent;
		int file_idx;
		sent = 0;
		file_idx = 0;
		mismatches = 0;
		idle_cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		data_byte = '0;
		start_of_file = 1'b0;
		reset_parser();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[k]) begin
			calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < dir_rows[k].text.len(); i++)
				send_byte(dir_rows[k].text[i], dir_rows[k].sof && i == 0,
					dir_rows[k].typed, dir_rows[k].want);
		end

		while (sent < RANDOM_BYTES) begin
			calm = ($urandom_range(0, 3) == 0);
			// hold off once until every header result is back
			if (file_idx == 5 && pending_headers.size() != 0) begin
				byte_valid <= 1'b0;
				while (pending_headers.size() != 0)
					@(negedge clk);
			end
			build_file();
			foreach (file_q[i])
				send_byte(file_q[i], i == 0, 1'b0, UNTYPED);
			sent += file_q.size();
			// pixel bytes and other traffic after the header
			repeat ($urandom_range(0, 4)) begin
				send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, UNTYPED);
				sent++;
			end
			file_idx++;
		end

		byte_valid <= 1'b0;
		while (pending_headers.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
